// File: hdl/tcip_pkg.sv
// ----------------------------------------------------------------------------
// tcip_pkg
// Shared types and constants of the terminal canonical input processor:
// result kinds, register indexes, control characters and reset values.
// ----------------------------------------------------------------------------
package tcip_pkg;

   // result kinds
   localparam logic [2:0] KIND_DATA = 3'd0;
   localparam logic [2:0] KIND_ECHO = 3'd1;
   localparam logic [2:0] KIND_EOF  = 3'd2;
   localparam logic [2:0] KIND_INTR = 3'd3;
   localparam logic [2:0] KIND_QUIT = 3'd4;

   // control register indexes
   localparam logic [2:0] REG_INPUT_MODE = 3'd0;
   localparam logic [2:0] REG_LOCAL_MODE = 3'd1;
   localparam logic [2:0] REG_INTR_CHAR  = 3'd2;
   localparam logic [2:0] REG_QUIT_CHAR  = 3'd3;
   localparam logic [2:0] REG_ERASE_CHAR = 3'd4;
   localparam logic [2:0] REG_KILL_CHAR  = 3'd5;
   localparam logic [2:0] REG_EOF_CHAR   = 3'd6;
   localparam logic [2:0] REG_EOL_CHAR   = 3'd7;

   // register reset values
   localparam logic [2:0] INPUT_MODE_RST = 3'd2;
   localparam logic [6:0] LOCAL_MODE_RST = 7'd95;
   localparam logic [7:0] INTR_CHAR_RST  = 8'd3;
   localparam logic [7:0] QUIT_CHAR_RST  = 8'd28;
   localparam logic [7:0] ERASE_CHAR_RST = 8'h7f;
   localparam logic [7:0] KILL_CHAR_RST  = 8'd21;
   localparam logic [7:0] EOF_CHAR_RST   = 8'd4;
   localparam logic [7:0] EOL_CHAR_RST   = 8'd0;

   // fixed characters
   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_NL = 8'h0a;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_SP = 8'h20;

   // results per request are capped
   localparam int RESULTS_MAX = 50;
   localparam int CNT_W       = $clog2(RESULTS_MAX + 1);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       end_of_record;
      logic       last;
   } result_type;

endpackage

// File: hdl/tcip_ram.sv
// ----------------------------------------------------------------------------
// tcip_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tcip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tty_canonical_input_processor_unit.sv
// ----------------------------------------------------------------------------
// tty_canonical_input_processor_unit
// Read side of a terminal line discipline: input CR/NL mapping, signal
// characters, raw pass-through and canonical line editing with echo.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is first accepted and then
// decoded; its results then follow one by one while the result side takes
// them, and each stored byte sent upstream on line delivery first needs a
// read of the line store. The line store is a synchronous RAM of LINE_MAX
// bytes; the line length is held in a register, and only entries below it
// are read. Results of one request are capped at 50; the last one carries
// rsp_last.
// ----------------------------------------------------------------------------
module tty_canonical_input_processor_unit
   import tcip_pkg::*;
#(
   parameter int LINE_MAX = 16
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_end_of_record,
   output logic       rsp_last,
   // control registers
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);

   localparam int LEN_W  = $clog2(LINE_MAX + 1);
   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int TOT_W  = LEN_W + 2;

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DECODE    = 4'd1;
   localparam logic [3:0] ST_ECHO      = 4'd2;
   localparam logic [3:0] ST_ECHO_CR   = 4'd3;
   localparam logic [3:0] ST_RUB_BS1   = 4'd4;
   localparam logic [3:0] ST_RUB_SP    = 4'd5;
   localparam logic [3:0] ST_RUB_BS2   = 4'd6;
   localparam logic [3:0] ST_KILL_NL   = 4'd7;
   localparam logic [3:0] ST_KILL_CR   = 4'd8;
   localparam logic [3:0] ST_SIG       = 4'd9;
   localparam logic [3:0] ST_RAW_DATA  = 4'd10;
   localparam logic [3:0] ST_EOF_MARK  = 4'd11;
   localparam logic [3:0] ST_READ      = 4'd12;
   localparam logic [3:0] ST_READ_DATA = 4'd13;
   localparam logic [3:0] ST_TERM      = 4'd14;

   // request classes that steer the sequence after an echo
   localparam logic [1:0] OP_OTHER = 2'd0;
   localparam logic [1:0] OP_RAW   = 2'd1;
   localparam logic [1:0] OP_LINE  = 2'd2;
   localparam logic [1:0] OP_EOF   = 2'd3;

   // control registers
   logic [2:0] input_mode_ff;
   logic [6:0] local_mode_ff;
   logic [7:0] intr_char_ff, quit_char_ff, erase_char_ff;
   logic [7:0] kill_char_ff, eof_char_ff, eol_char_ff;

   // sequencer registers
   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [7:0]       byte_ff, byte_in;
   logic [1:0]       op_ff, op_in;
   logic             quit_ff, quit_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_res_ff;

   // combinational
   logic              req_accept;
   logic              out_free;
   logic              emit;
   logic              res_load;
   logic              res_last;
   logic [CNT_W-1:0]  count_inc;
   result_type        res;
   logic [3:0]        next_st;
   logic [3:0]        start_st;
   logic [3:0]        after_echo;
   logic [3:0]        rub_next;
   logic [7:0]        mb;
   logic              ign;
   logic              is_sig;
   logic              echo_on;
   logic [TOT_W-1:0]  echo_n;
   logic [TOT_W-1:0]  len_x;
   logic [TOT_W-1:0]  rub_k;
   logic [TOT_W-1:0]  rub_all;
   logic [TOT_W-1:0]  tot_raw;
   logic              wr_en;
   logic              rd_en;
   logic [7:0]        rd_data;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign echo_on    = local_mode_ff[2];
   assign count_inc  = CNT_W'(count_ff + 1'b1);
   assign res_last   = (count_inc == total_ff);

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         input_mode_ff <= INPUT_MODE_RST;
         local_mode_ff <= LOCAL_MODE_RST;
         intr_char_ff  <= INTR_CHAR_RST;
         quit_char_ff  <= QUIT_CHAR_RST;
         erase_char_ff <= ERASE_CHAR_RST;
         kill_char_ff  <= KILL_CHAR_RST;
         eof_char_ff   <= EOF_CHAR_RST;
         eol_char_ff   <= EOL_CHAR_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_INPUT_MODE: input_mode_ff <= csr_write_data[2:0];
            REG_LOCAL_MODE: local_mode_ff <= csr_write_data[6:0];
            REG_INTR_CHAR:  intr_char_ff  <= csr_write_data;
            REG_QUIT_CHAR:  quit_char_ff  <= csr_write_data;
            REG_ERASE_CHAR: erase_char_ff <= csr_write_data;
            REG_KILL_CHAR:  kill_char_ff  <= csr_write_data;
            REG_EOF_CHAR:   eof_char_ff   <= csr_write_data;
            REG_EOL_CHAR:   eol_char_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input mapping and result counts for the byte under decode
   always_comb begin
      mb  = byte_ff;
      ign = 1'b0;
      if (byte_ff == CHAR_CR) begin
         if (input_mode_ff[0]) begin
            ign = 1'b1;
         end else if (input_mode_ff[1]) begin
            mb = CHAR_NL;
         end
      end else if (byte_ff == CHAR_NL && input_mode_ff[2]) begin
         mb = CHAR_CR;
      end
      is_sig  = local_mode_ff[0] && (mb == intr_char_ff || mb == quit_char_ff);
      echo_n  = TOT_W'(echo_on) +
                TOT_W'(echo_on && mb == CHAR_NL && local_mode_ff[6]);
      len_x   = TOT_W'(len_ff);
      rub_k   = local_mode_ff[3] ? TOT_W'(3) : TOT_W'(1);
      rub_all = local_mode_ff[3] ? TOT_W'(len_x + (len_x << 1)) : len_x;
   end

   // where an echo or a rubout leads next
   always_comb begin
      unique case (op_ff)
         OP_RAW:  after_echo = ST_RAW_DATA;
         OP_LINE: after_echo = (cnt_ff != '0) ? ST_READ : ST_TERM;
         default: after_echo = ST_IDLE;
      endcase
      rub_next = (cnt_ff > LEN_W'(1)) ? ST_RUB_BS1 : ST_KILL_NL;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      op_in    = op_ff;
      quit_in  = quit_ff;
      total_in = total_ff;
      count_in = count_ff;
      res      = '0;
      emit     = 1'b0;
      next_st  = ST_IDLE;
      start_st = ST_IDLE;
      tot_raw  = '0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in  = req_in_byte;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            byte_in  = mb;
            count_in = '0;
            idx_in   = '0;
            op_in    = OP_OTHER;
            if (ign) begin
               tot_raw = '0;
            end else if (is_sig) begin
               if (!local_mode_ff[5]) begin
                  len_in = '0;
               end
               quit_in  = (mb != intr_char_ff);
               start_st = ST_SIG;
               tot_raw  = TOT_W'(1);
            end else if (!local_mode_ff[1]) begin
               op_in    = OP_RAW;
               start_st = echo_on ? ST_ECHO : ST_RAW_DATA;
               tot_raw  = TOT_W'(echo_n + 1'b1);
            end else if (mb == erase_char_ff) begin
               cnt_in   = LEN_W'(1);
               start_st = ST_RUB_BS1;
               if (len_ff != '0) begin
                  len_in  = LEN_W'(len_ff - 1'b1);
                  tot_raw = echo_on ? rub_k : '0;
               end
            end else if (mb == kill_char_ff) begin
               cnt_in   = len_ff;
               len_in   = '0;
               start_st = (len_ff != '0) ? ST_RUB_BS1 : ST_KILL_NL;
               tot_raw  = TOT_W'((echo_on ? rub_all : '0) +
                          ((echo_on && local_mode_ff[4]) ?
                           TOT_W'(TOT_W'(1) + TOT_W'(local_mode_ff[6])) : '0));
            end else if (mb == eof_char_ff) begin
               op_in    = OP_EOF;
               cnt_in   = len_ff;
               len_in   = '0;
               start_st = (len_ff == '0) ? ST_EOF_MARK : ST_READ;
               tot_raw  = (len_ff == '0) ? TOT_W'(1) : len_x;
            end else if (mb == CHAR_NL || (eol_char_ff != '0 && mb == eol_char_ff)) begin
               op_in    = OP_LINE;
               cnt_in   = len_ff;
               len_in   = '0;
               start_st = echo_on ? ST_ECHO : ((len_ff != '0) ? ST_READ : ST_TERM);
               tot_raw  = TOT_W'(echo_n + len_x + 1'b1);
            end else begin
               start_st = ST_ECHO;
               tot_raw  = echo_n;
               if (len_ff < LEN_W'(LINE_MAX)) begin
                  wr_en  = 1'b1;
                  len_in = LEN_W'(len_ff + 1'b1);
               end
            end
            // cap the number of results of one request
            if (32'(tot_raw) > RESULTS_MAX) begin
               total_in = CNT_W'(RESULTS_MAX);
            end else begin
               total_in = CNT_W'(tot_raw);
            end
            state_in = (tot_raw == '0) ? ST_IDLE : start_st;
         end
         ST_ECHO: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = byte_ff;
            next_st  = (byte_ff == CHAR_NL && local_mode_ff[6]) ? ST_ECHO_CR : after_echo;
         end
         ST_ECHO_CR: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = CHAR_CR;
            next_st  = after_echo;
         end
         ST_RUB_BS1: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = CHAR_BS;
            next_st  = local_mode_ff[3] ? ST_RUB_SP : rub_next;
            if (out_free && !local_mode_ff[3]) begin
               cnt_in = LEN_W'(cnt_ff - 1'b1);
            end
         end
         ST_RUB_SP: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = CHAR_SP;
            next_st  = ST_RUB_BS2;
         end
         ST_RUB_BS2: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = CHAR_BS;
            next_st  = rub_next;
            if (out_free) begin
               cnt_in = LEN_W'(cnt_ff - 1'b1);
            end
         end
         ST_KILL_NL: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = CHAR_NL;
            next_st  = ST_KILL_CR;
         end
         ST_KILL_CR: begin
            emit     = 1'b1;
            res.kind = KIND_ECHO;
            res.data = CHAR_CR;
         end
         ST_SIG: begin
            emit     = 1'b1;
            res.kind = quit_ff ? KIND_QUIT : KIND_INTR;
         end
         ST_RAW_DATA: begin
            emit              = 1'b1;
            res.kind          = KIND_DATA;
            res.data          = byte_ff;
            res.end_of_record = 1'b1;
         end
         ST_EOF_MARK: begin
            emit     = 1'b1;
            res.kind = KIND_EOF;
         end
         ST_READ: begin
            // fetch the next stored byte, data shows up next cycle
            rd_en    = 1'b1;
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            emit              = 1'b1;
            res.kind          = KIND_DATA;
            res.data          = rd_data;
            res.end_of_record = (op_ff == OP_EOF) && (cnt_ff == LEN_W'(1));
            next_st           = (cnt_ff > LEN_W'(1)) ? ST_READ :
                                ((op_ff == OP_LINE) ? ST_TERM : ST_IDLE);
            if (out_free) begin
               cnt_in = LEN_W'(cnt_ff - 1'b1);
               idx_in = ADDR_W'(idx_ff + 1'b1);
            end
         end
         ST_TERM: begin
            emit              = 1'b1;
            res.kind          = KIND_DATA;
            res.data          = CHAR_NL;
            res.end_of_record = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand a result to the output register
      res_load = emit && out_free;
      res.last = res_last;
      if (res_load) begin
         count_in = count_inc;
         state_in = res_last ? ST_IDLE : next_st;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         op_ff    <= OP_OTHER;
         quit_ff  <= 1'b0;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         op_ff    <= op_in;
         quit_ff  <= quit_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_res_ff.kind;
   assign rsp_data          = rsp_res_ff.data;
   assign rsp_end_of_record = rsp_res_ff.end_of_record;
   assign rsp_last          = rsp_res_ff.last;

   // line store
   tcip_ram #(
      .WIDTH (8),
      .DEPTH (LINE_MAX)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (mb),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

`ifndef ASSERT_OFF
   // line length stays within the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_MAX))
      else $error("line length beyond store depth");

   // no result is produced beyond the planned count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_DECODE && state_ff != ST_READ) |->
      count_ff < total_ff)
      else $error("result count overrun");

   // the final result of a request frees the sequencer
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_last) |=> state_ff == ST_IDLE)
      else $error("sequencer busy after final result");

   // a store read is always followed by its data cycle
   a_read_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_READ_DATA)
      else $error("store read not followed by data cycle");
`endif

endmodule
